/* hw/rtl/sact_pkg.sv */
`default_nettype none
package sact_pkg;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WRITE_POLICY   = 3'd0;
  localparam logic [2:0] CFG_REPLACE_POLICY = 3'd1;
  localparam logic [2:0] CFG_LINE_SIZE_LOG2 = 3'd2;
  localparam logic [2:0] CFG_LINES_LOG2     = 3'd3;
  localparam logic [2:0] CFG_WAYS_LOG2      = 3'd4;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'd42;

  localparam int TAG_W  = 32;
  localparam int WAY_W  = 3;
  localparam int RANK_W = 3;
  localparam int MW_W   = 9;
  localparam logic [MW_W-1:0] MW_SAT = 9'd511;

  typedef struct packed {
    logic       wb_mode;
    logic       rand_repl;
    logic [3:0] line_size_log2;
    logic [3:0] lines_log2;
    logic [1:0] ways_log2;
  } cfg_t;

  typedef struct packed {
    req_t             kind;
    logic [1:0]       wl;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic            hit;
    logic            mem_read;
    logic [MW_W-1:0] mem_writes;
    logic            allocated;
    logic [WAY_W-1:0] way_used;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_FLUSH = 2'd2
  } bstate_t;

endpackage
`default_nettype wire

/* hw/rtl/sact_ram.sv */
`default_nettype none
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/sact_front.sv */
`default_nettype none
module sact_front #(
  parameter int LL_MAX = 8,
  parameter int WL_MAX = 3,
  parameter int LN_W   = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sact_pkg::cfg_t       cfg,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [31:0]          in_address,
  output logic                      cmd_valid,
  input  wire logic                 cmd_pop,
  output sact_pkg::cmd_t            cmd,
  output logic [LN_W-1:0]           cmd_line
);

  sact_pkg::cmd_t  q_cmd_r  [2];
  logic [LN_W-1:0] q_line_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;

  logic [3:0]      ll, wl4, sl;
  logic [31:0]     block, set_v, tag;
  sact_pkg::cmd_t  dec_cmd;
  logic [LN_W-1:0] dec_line;
  logic            push_ok, pop_ok;

  // Split the address into set and tag for the current geometry.
  always_comb begin
    ll  = (cfg.lines_log2 > 4'(LL_MAX)) ? 4'(LL_MAX) : cfg.lines_log2;
    wl4 = {2'b00, cfg.ways_log2};
    if (wl4 > 4'(WL_MAX)) wl4 = 4'(WL_MAX);
    if (wl4 > ll) wl4 = ll;
    sl       = ll - wl4;
    block    = in_address >> cfg.line_size_log2;
    set_v    = block & ((32'd1 << sl) - 32'd1);
    tag      = block >> sl;
    dec_line = LN_W'(set_v << wl4);
    dec_cmd.kind = sact_pkg::req_t'(in_req_type);
    dec_cmd.wl   = wl4[1:0];
    dec_cmd.tag  = tag;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_cmd_r[rd_ptr_r];
  assign cmd_line  = q_line_r[rd_ptr_r];

  // Two-entry command queue toward the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= !wr_ptr_r;
      if (pop_ok) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_cmd_r[wr_ptr_r]  <= dec_cmd;
      q_line_r[wr_ptr_r] <= dec_line;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sact_back.sv */
`default_nettype none
module sact_back #(
  parameter int WL_MAX = 3,
  parameter int WAYS   = 8,
  parameter int ROWS   = 32,
  parameter int ROW_W  = 5,
  parameter int BANK_W = 3,
  parameter int LN_W   = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sact_pkg::cfg_t    cfg,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  input  wire sact_pkg::cmd_t    cmd,
  input  wire logic [LN_W-1:0]   cmd_line,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output sact_pkg::result_t      out_res
);

  localparam int ENT_W = sact_pkg::TAG_W + sact_pkg::RANK_W;
  localparam int ROW_D = WAYS * ENT_W;

  sact_pkg::bstate_t state_r, state_nxt;
  sact_pkg::cmd_t    cur_cmd_r;
  logic [LN_W-1:0]   cur_line_r;
  logic [WAYS-1:0]   valid_r [ROWS];
  logic [WAYS-1:0]   dirty_r [ROWS];
  logic [15:0]       lfsr_r;
  logic [ROW_W-1:0]  fr_r, fr_nxt;
  logic [sact_pkg::MW_W-1:0] acc_r, acc_nxt;

  sact_pkg::result_t oq_r [2];
  logic              oq_wp_r, oq_rp_r;
  logic [1:0]        oq_cnt_r;
  logic              out_push;
  sact_pkg::result_t push_res;
  logic              oq_pop_ok;

  logic              ram_we;
  logic [ROW_D-1:0]  ram_wdata, ram_rdata;
  logic [ROW_W-1:0]  ram_raddr;

  // Evaluation signals.
  logic [ROW_W-1:0]  row_q;
  logic [BANK_W-1:0] off, hb, ib, lb, rb, vb, tb;
  logic [WAYS-1:0]   in_set, vrow, drow;
  logic [sact_pkg::TAG_W-1:0]  tag_j  [WAYS];
  logic [sact_pkg::RANK_W-1:0] rank_j [WAYS];
  logic [sact_pkg::RANK_W-1:0] new_rank [WAYS];
  logic [sact_pkg::WAY_W-1:0]  ways_m1;
  logic [sact_pkg::RANK_W-1:0] old_rank, br;
  logic              hit_found, inv_found, lru_set;
  logic              is_rw, is_wr, hit, wt_miss, alloc, touch, lfsr_adv;
  logic [15:0]       lfsr_step;
  logic [sact_pkg::MW_W-1:0] ev_mw;
  logic [sact_pkg::MW_W:0]   fl_sum;
  logic [sact_pkg::MW_W-1:0] fl_pop;
  logic [WAYS-1:0]   fl_bits;
  logic              start_ok;

  sact_ram #(.WIDTH(ROW_D), .DEPTH(ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_q),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign start_ok  = cmd_valid && (oq_cnt_r != 2'd2);
  assign ram_raddr = ROW_W'(cmd_line >> WL_MAX);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sact_pkg::ST_IDLE: begin
        if (start_ok) begin
          state_nxt = (cmd.kind == sact_pkg::REQ_FLUSH) ? sact_pkg::ST_FLUSH : sact_pkg::ST_EVAL;
        end
      end
      sact_pkg::ST_EVAL: state_nxt = sact_pkg::ST_IDLE;
      sact_pkg::ST_FLUSH: begin
        if (fr_r == ROW_W'(ROWS - 1)) state_nxt = sact_pkg::ST_IDLE;
      end
      default: state_nxt = sact_pkg::ST_IDLE;
    endcase
  end

  // Look up the set read from the tag memory and work out the outcome.
  always_comb begin
    row_q   = ROW_W'(cur_line_r >> WL_MAX);
    off     = BANK_W'(cur_line_r & LN_W'(WAYS - 1));
    ways_m1 = sact_pkg::WAY_W'((4'd1 << cur_cmd_r.wl) - 4'd1);
    vrow    = valid_r[row_q];
    drow    = dirty_r[row_q];
    hit_found = 1'b0; inv_found = 1'b0; lru_set = 1'b0;
    hb = '0; ib = '0; lb = '0; br = '0;
    for (int j = 0; j < WAYS; j++) begin
      tag_j[j]  = ram_rdata[j*ENT_W + sact_pkg::RANK_W +: sact_pkg::TAG_W];
      rank_j[j] = ram_rdata[j*ENT_W +: sact_pkg::RANK_W];
      in_set[j] = ((BANK_W'(j) ^ off) >> cur_cmd_r.wl) == '0;
      if (!hit_found && in_set[j] && vrow[j] && tag_j[j] == cur_cmd_r.tag) begin
        hit_found = 1'b1;
        hb = BANK_W'(j);
      end
      if (!inv_found && in_set[j] && !vrow[j]) begin
        inv_found = 1'b1;
        ib = BANK_W'(j);
      end
      if (in_set[j] && (!lru_set || rank_j[j] > br)) begin
        lru_set = 1'b1;
        lb = BANK_W'(j);
        br = rank_j[j];
      end
    end
    lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? sact_pkg::LFSR_TAPS : 16'd0);
    rb = off | BANK_W'(lfsr_step[sact_pkg::WAY_W-1:0] & ways_m1);
    vb = inv_found ? ib : (cfg.rand_repl ? rb : lb);

    is_rw   = (cur_cmd_r.kind == sact_pkg::REQ_READ) || (cur_cmd_r.kind == sact_pkg::REQ_WRITE);
    is_wr   = (cur_cmd_r.kind == sact_pkg::REQ_WRITE);
    hit     = is_rw && hit_found;
    wt_miss = is_rw && !hit_found && is_wr && !cfg.wb_mode;
    alloc   = is_rw && !hit_found && !wt_miss;
    touch   = hit || alloc;
    lfsr_adv = alloc && !inv_found && cfg.rand_repl;
    tb      = hit ? hb : vb;

    ev_mw = '0;
    if ((hit && is_wr && !cfg.wb_mode) || wt_miss) ev_mw = 9'd1;
    if (alloc && vrow[tb] && drow[tb]) ev_mw = 9'd1;

    // Recency update: the touched way becomes most recent.
    old_rank = vrow[tb] ? rank_j[tb] : ways_m1;
    for (int j = 0; j < WAYS; j++) begin
      new_rank[j] = rank_j[j];
      if (BANK_W'(j) == tb) begin
        new_rank[j] = '0;
      end else if (in_set[j] && vrow[j] && rank_j[j] < old_rank) begin
        new_rank[j] = rank_j[j] + 1'b1;
      end
      ram_wdata[j*ENT_W +: ENT_W] = {
        (alloc && BANK_W'(j) == tb) ? cur_cmd_r.tag : tag_j[j], new_rank[j]};
    end

    // Flush row count.
    fl_bits = valid_r[fr_r] & dirty_r[fr_r];
    fl_pop  = '0;
    for (int j = 0; j < WAYS; j++) begin
      fl_pop = fl_pop + sact_pkg::MW_W'(fl_bits[j]);
    end
    fl_sum = {1'b0, acc_r} + {1'b0, fl_pop};
  end

  // Datapath controls per state.
  always_comb begin
    cmd_pop  = 1'b0;
    ram_we   = 1'b0;
    out_push = 1'b0;
    push_res = '0;
    fr_nxt   = fr_r;
    acc_nxt  = acc_r;
    case (state_r)
      sact_pkg::ST_IDLE: begin
        cmd_pop = start_ok;
        fr_nxt  = '0;
        acc_nxt = '0;
      end
      sact_pkg::ST_EVAL: begin
        ram_we   = touch;
        out_push = 1'b1;
        push_res.hit        = hit;
        push_res.mem_read   = alloc;
        push_res.mem_writes = ev_mw;
        push_res.allocated  = alloc;
        push_res.way_used   = touch ? (sact_pkg::WAY_W'(tb) & ways_m1) : '0;
      end
      sact_pkg::ST_FLUSH: begin
        fr_nxt  = fr_r + 1'b1;
        acc_nxt = (fl_sum > {1'b0, sact_pkg::MW_SAT}) ? sact_pkg::MW_SAT : fl_sum[sact_pkg::MW_W-1:0];
        if (fr_r == ROW_W'(ROWS - 1)) begin
          out_push = 1'b1;
          push_res.mem_writes = acc_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sact_pkg::ST_IDLE;
      lfsr_r  <= sact_pkg::LFSR_SEED;
      fr_r    <= '0;
      acc_r   <= '0;
      for (int r = 0; r < ROWS; r++) begin
        valid_r[r] <= '0;
        dirty_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fr_r    <= fr_nxt;
      acc_r   <= acc_nxt;
      if (state_r == sact_pkg::ST_EVAL) begin
        if (lfsr_adv) lfsr_r <= lfsr_step;
        if (alloc) begin
          valid_r[row_q][tb] <= 1'b1;
          dirty_r[row_q][tb] <= is_wr;
        end
        if (hit && is_wr && cfg.wb_mode) dirty_r[row_q][tb] <= 1'b1;
      end
      if (state_r == sact_pkg::ST_FLUSH) dirty_r[fr_r] <= '0;
    end
  end

  // Capture the command being worked on.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_cmd_r  <= cmd;
      cur_line_r <= cmd_line;
    end
  end

  // Two-entry result queue.
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop_ok = out_pop && !out_empty;
  assign out_res   = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (out_push) oq_wp_r <= !oq_wp_r;
      if (oq_pop_ok) oq_rp_r <= !oq_rp_r;
      oq_cnt_r <= oq_cnt_r + 2'(out_push) - 2'(oq_pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) oq_r[oq_wp_r] <= push_res;
  end

  a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sact_pkg::ST_EVAL) |=> (state_r == sact_pkg::ST_IDLE))
    else $error("lookup lasted more than one cycle");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (oq_cnt_r != 2'd2))
    else $error("result queue overflow");

  a_eval_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sact_pkg::ST_EVAL) |-> $past(cmd_pop))
    else $error("lookup without a command");

endmodule
`default_nettype wire

/* hw/rtl/set_assoc_cache_tag_controller.sv */
// Set-associative cache tag controller.
// Requests enter on the in_ channel (push/full) as a request type and a byte
// address; one result per request leaves on the out_ channel (empty/pop) with
// hit, mem_read, mem_writes, allocated and way_used.
// A front end splits the address into set and tag and queues the command; a
// back end reads the set's tags and recency ranks from a row-wide memory in
// IDLE and evaluates and writes them back in the next cycle, in EVAL. The back
// end takes no new command until that read-modify-write of the tag memory row
// is done; a read or write result is pushed to the output queue from EVAL.
// A flush walks the valid/dirty bits one row of WAYS_MAX lines per cycle over
// all LINES_MAX / WAYS_MAX rows (32 at the defaults).
// Reset clears all valid and dirty bits at once, loads the LFSR seed and the
// default geometry; no clearing pass is needed. When the receiver stalls,
// results wait in a two-entry output queue and commands in a two-entry input
// queue; full rises once both are backed up. Configuration is written through
// cfg_we/cfg_index/cfg_data while no transaction is in flight.
`default_nettype none
module set_assoc_cache_tag_controller #(
  parameter int LINES_MAX = 256,
  parameter int WAYS_MAX  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_push,
  output logic             full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_address,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_hit,
  output logic             out_mem_read,
  output logic [8:0]       out_mem_writes,
  output logic             out_allocated,
  output logic [2:0]       out_way_used
);

  localparam int LL_MAX = $clog2(LINES_MAX + 1) - 1;
  localparam int WL_MAX = $clog2(WAYS_MAX + 1) - 1;
  localparam int WAYS   = 1 << WL_MAX;
  localparam int LINES  = 1 << LL_MAX;
  localparam int ROWS   = (LINES >= WAYS) ? LINES / WAYS : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BANK_W = (WL_MAX > 0) ? WL_MAX : 1;
  localparam int LN_W   = ((LL_MAX > WL_MAX) ? LL_MAX : WL_MAX) + 1;

  sact_pkg::cfg_t    cfg_r;
  sact_pkg::cmd_t    cmd;
  logic [LN_W-1:0]   cmd_line;
  logic              cmd_valid, cmd_pop;
  sact_pkg::result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wb_mode        <= 1'b0;
      cfg_r.rand_repl      <= 1'b0;
      cfg_r.line_size_log2 <= 4'd6;
      cfg_r.lines_log2     <= 4'd7;
      cfg_r.ways_log2      <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        sact_pkg::CFG_WRITE_POLICY:   cfg_r.wb_mode        <= cfg_data[0];
        sact_pkg::CFG_REPLACE_POLICY: cfg_r.rand_repl      <= cfg_data[0];
        sact_pkg::CFG_LINE_SIZE_LOG2: cfg_r.line_size_log2 <= cfg_data;
        sact_pkg::CFG_LINES_LOG2:     cfg_r.lines_log2     <= cfg_data;
        sact_pkg::CFG_WAYS_LOG2:      cfg_r.ways_log2      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  sact_front #(.LL_MAX(LL_MAX), .WL_MAX(WL_MAX), .LN_W(LN_W)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_push     (in_push),
    .in_full     (full),
    .in_req_type (in_req_type),
    .in_address  (in_address),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .cmd_line    (cmd_line)
  );

  sact_back #(
    .WL_MAX(WL_MAX), .WAYS(WAYS), .ROWS(ROWS), .ROW_W(ROW_W),
    .BANK_W(BANK_W), .LN_W(LN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_line  (cmd_line),
    .out_empty (empty),
    .out_pop   (pop),
    .out_res   (res)
  );

  assign out_hit        = res.hit;
  assign out_mem_read   = res.mem_read;
  assign out_mem_writes = res.mem_writes;
  assign out_allocated  = res.allocated;
  assign out_way_used   = res.way_used;

endmodule
`default_nettype wire
